/* hw/rtl/sliding_window_maximum_macros.svh */
// ----------------------------------------------------------------------------
// Sliding window maximum: assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAXIMUM_MACROS_SVH
`define SLIDING_WINDOW_MAXIMUM_MACROS_SVH

// same-cycle implication
`define SWM_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/swm_pkg.sv */
// ----------------------------------------------------------------------------
// Sliding window maximum: package
// Sizes, payload types and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package swm_pkg;

   // queue depth, a power of two (positions wrap at twice the depth)
   localparam int WINDOW_MAX   = 64;
   localparam int SAMPLE_WIDTH = 16;
   localparam int CFG_WIDTH    = 7;
   localparam int QUEUE_AW     = $clog2(WINDOW_MAX);
   localparam int QUEUE_CW     = QUEUE_AW + 1;
   localparam int POS_WIDTH    = QUEUE_AW + 1;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [CFG_WIDTH-1:0]           cfg_type;
   typedef logic [QUEUE_AW-1:0]            addr_type;
   typedef logic [QUEUE_CW-1:0]            count_type;
   typedef logic [POS_WIDTH-1:0]           pos_type;

   // one queue entry: candidate value and its stream position
   typedef struct packed {
      sample_type value;
      pos_type    age;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic front_pop;
      logic front_stop;
      logic back_pop;
      logic back_stop;
      logic load_out;
      logic out_from_pend;
   } swm_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic front_old;
      logic back_le;
      logic emit;
      logic out_busy;
   } swm_status_type;

endpackage

/* hw/rtl/swm_req_if.sv */
// ----------------------------------------------------------------------------
// Sliding window maximum: sample channel
// Valid/ready channel carrying one input sample beat.
// ----------------------------------------------------------------------------
interface swm_req_if import swm_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       first;
   logic       last;

   modport source (output valid, output sample, output first, output last, input ready);
   modport sink   (input valid, input sample, input first, input last, output ready);
endinterface

/* hw/rtl/swm_rsp_if.sv */
// ----------------------------------------------------------------------------
// Sliding window maximum: result channel
// Valid/ready channel carrying one window maximum beat.
// ----------------------------------------------------------------------------
interface swm_rsp_if import swm_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type window_max;
   logic       end_of_run;

   modport source (output valid, output window_max, output end_of_run, input ready);
   modport sink   (input valid, input window_max, input end_of_run, output ready);
endinterface

/* hw/rtl/swm_csr_if.sv */
// ----------------------------------------------------------------------------
// Sliding window maximum: register write channel
// Valid/ready channel carrying the window length write data.
// ----------------------------------------------------------------------------
interface swm_csr_if import swm_pkg::*; ();
   logic    valid;
   logic    ready;
   cfg_type window_len;

   modport source (output valid, output window_len, input ready);
   modport sink   (input valid, input window_len, output ready);
endinterface

/* hw/rtl/swm_ctrl.sv */
// ----------------------------------------------------------------------------
// Sliding window maximum: controller
// Sequences one sample: head read, front drops, back drops and push, result.
// ----------------------------------------------------------------------------
module swm_ctrl import swm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  swm_status_type status,
   output swm_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FRONT,
      ST_BACK,
      ST_HOLD
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_FRONT;
            end
         end
         ST_FRONT: begin
            if (status.front_old) begin
               cmd.front_pop = 1'b1;
            end else begin
               cmd.front_stop = 1'b1;
               state_in       = ST_BACK;
            end
         end
         ST_BACK: begin
            if (status.back_le) begin
               cmd.back_pop = 1'b1;
            end else begin
               cmd.back_stop = 1'b1;
               if (status.emit && status.out_busy) begin
                  state_in = ST_HOLD;
               end else begin
                  cmd.load_out = status.emit;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_HOLD: begin
            if (!status.out_busy) begin
               cmd.load_out      = 1'b1;
               cmd.out_from_pend = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/swm_datapath.sv */
// ----------------------------------------------------------------------------
// Sliding window maximum: datapath
// Queue memory, head/count/position/fill registers, compares, result register.
// ----------------------------------------------------------------------------
module swm_datapath import swm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  sample_type     req_sample,
   input  logic           req_first,
   input  logic           req_last,
   input  logic           csr_valid,
   input  cfg_type        csr_window_len,
   input  swm_cmd_type    cmd,
   output swm_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output sample_type     rsp_window_max,
   output logic           rsp_end_of_run
);

   `include "sliding_window_maximum_macros.svh"

   entry_type  mem [WINDOW_MAX];
   entry_type  rd_data_ff;
   addr_type   rd_addr;
   addr_type   wr_addr;
   logic       wr_en;

   cfg_type    window_len_ff;
   count_type  len_eff;
   addr_type   head_ff,  head_in;
   count_type  count_ff, count_in;
   pos_type    pos_ff,   pos_in;
   count_type  fill_ff,  fill_in;
   count_type  fill_base;
   pos_type    age_diff;

   sample_type sample_ff;
   logic       last_ff;
   sample_type front_val_ff;
   sample_type pend_max_ff;
   sample_type result_live;

   logic       rsp_valid_ff;
   sample_type rsp_max_ff;
   logic       rsp_last_ff;

   // window length register
   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= CFG_WIDTH'(1);
      end else if (csr_valid) begin
         window_len_ff <= csr_window_len;
      end
   end

   // zero means one, saturate at queue depth
   always_comb begin
      if (window_len_ff == '0) begin
         len_eff = QUEUE_CW'(1);
      end else if (window_len_ff > CFG_WIDTH'(WINDOW_MAX)) begin
         len_eff = QUEUE_CW'(WINDOW_MAX);
      end else begin
         len_eff = QUEUE_CW'(window_len_ff);
      end
   end

   // queue pointer and sequence counters
   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      fill_in   = fill_ff;
      fill_base = req_first ? '0 : fill_ff;
      if (cmd.accept) begin
         head_in  = req_first ? '0 : head_ff;
         count_in = req_first ? '0 : count_ff;
         pos_in   = req_first ? '0 : pos_ff;
         fill_in  = (fill_base < QUEUE_CW'(WINDOW_MAX)) ? fill_base + 1'b1 : fill_base;
      end else if (cmd.front_pop) begin
         head_in  = head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end else if (cmd.back_pop) begin
         count_in = count_ff - 1'b1;
      end else if (cmd.back_stop) begin
         if (count_ff < QUEUE_CW'(WINDOW_MAX)) begin
            count_in = count_ff + 1'b1;
         end
         pos_in = pos_ff + 1'b1;
      end
   end

   // read the head while checking age, the back while checking value
   always_comb begin
      if (cmd.accept || cmd.front_pop) begin
         rd_addr = head_in;
      end else begin
         rd_addr = head_in + count_in[QUEUE_AW-1:0] - 1'b1;
      end
   end

   assign wr_addr = head_ff + count_ff[QUEUE_AW-1:0];
   assign wr_en   = cmd.back_stop && (count_ff < QUEUE_CW'(WINDOW_MAX));

   // queue memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= '{value: sample_ff, age: pos_ff};
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         pos_ff   <= '0;
         fill_ff  <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         fill_ff  <= fill_in;
      end
   end

   // sample payload and candidate results
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample;
         last_ff   <= req_last;
      end
      if (cmd.front_stop) begin
         front_val_ff <= rd_data_ff.value;
      end
      if (cmd.back_stop) begin
         pend_max_ff <= result_live;
      end
   end

   // empty after back drops: the new sample is the front
   assign result_live = (count_ff == '0) ? sample_ff : front_val_ff;

   // status compares
   assign age_diff         = pos_ff - rd_data_ff.age;
   assign status.front_old = (count_ff != '0) && (QUEUE_CW'(age_diff) >= len_eff);
   assign status.back_le   = (count_ff != '0) && (rd_data_ff.value <= sample_ff);
   assign status.emit      = (fill_ff >= len_eff);
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_max_ff  <= cmd.out_from_pend ? pend_max_ff : result_live;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_max = rsp_max_ff;
   assign rsp_end_of_run = rsp_last_ff;

   // checks
   `SWM_ASSERT_HOLDS(a_count_within_fill, 1'b1, count_ff <= fill_ff, "queue holds more than seen")
   `SWM_ASSERT_HOLDS(a_no_overwrite, cmd.load_out, !status.out_busy, "result beat overwritten")
   `SWM_ASSERT_NEXT(a_emit_nonempty, cmd.load_out, count_ff != '0, "result from empty queue")

endmodule

/* hw/rtl/sliding_window_maximum.sv */
// Flow: a sample beat is accepted, then entries are dropped from the queue front,
//   then from the queue back, and, once the window has filled, the result is loaded.
// A new sample is accepted only after the last one is done, including any wait
//   of a finished result for rsp ready; each sample leaves the queue at most once,
//   and the queue memory has a single read port.
// Reset: queue empty, fill count and position zero, window_len 1.
// ----------------------------------------------------------------------------
// Sliding window maximum: top level
// Running maximum of the last window_len samples over a monotonic queue.
// ----------------------------------------------------------------------------
module sliding_window_maximum import swm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   swm_req_if.sink   req_if,
   swm_rsp_if.source rsp_if,
   swm_csr_if.sink   csr_if
);

   swm_cmd_type    cmd;
   swm_status_type status;

   // register writes always taken
   assign csr_if.ready = 1'b1;

   swm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   swm_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_sample     (req_if.sample),
      .req_first      (req_if.first),
      .req_last       (req_if.last),
      .csr_valid      (csr_if.valid),
      .csr_window_len (csr_if.window_len),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_window_max (rsp_if.window_max),
      .rsp_end_of_run (rsp_if.end_of_run)
   );

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// Sliding window maximum: testbench
// Sends sample beats through the block and checks every window maximum beat
// against a scoreboard. The scoreboard keeps its own monotonic candidate queue
// and window register. Stimulus starts with a short directed part. Random
// phases follow, each run at its own window length and idle pattern.
// ----------------------------------------------------------------------------
package swm_tb_pkg;
   import swm_pkg::*;

   class window_max_scoreboard;
      typedef struct packed {
         sample_type window_max;
         logic       end_of_run;
      } max_beat_type;

      cfg_type      window_len;
      sample_type   cand_value [WINDOW_MAX];
      pos_type      cand_pos [WINDOW_MAX];
      addr_type     head;
      int           count;
      pos_type      position;
      int           fill;
      max_beat_type expected_q [$];
      int           errors;

      function new();
         window_len = cfg_type'(1);
         errors     = 0;
         clear_sequence();
      endfunction

      function void clear_sequence();
         head     = '0;
         count    = 0;
         position = '0;
         fill     = 0;
      endfunction

      function void set_window_len(cfg_type v);
         window_len = v;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // update the candidate queue for one accepted sample beat
      function void note_sample(sample_type s, logic first, logic last);
         int           len;
         pos_type      age;
         addr_type     slot;
         logic         done;
         max_beat_type beat;
         // zero means one, anything above the queue depth saturates
         len = (window_len == 0) ? 1 :
               ((window_len > WINDOW_MAX) ? WINDOW_MAX : int'(window_len));
         if (first) clear_sequence();
         // front: drop candidates that have aged out of the window
         done = 1'b0;
         while (count > 0 && !done) begin
            age = position - cand_pos[head];
            if (age < len) done = 1'b1;
            else begin
               head = head + 1'b1;
               count--;
            end
         end
         // back: drop candidates not above the new sample (newer wins ties)
         done = 1'b0;
         while (count > 0 && !done) begin
            slot = addr_type'(int'(head) + count - 1);
            if (cand_value[slot] > s) done = 1'b1;
            else count--;
         end
         if (count < WINDOW_MAX) begin
            slot = addr_type'(int'(head) + count);
            cand_value[slot] = s;
            cand_pos[slot]   = position;
            count++;
         end
         position = position + 1'b1;
         if (fill < WINDOW_MAX) fill++;
         // a result only once the window has filled
         if (fill >= len) begin
            beat.window_max = cand_value[head];
            beat.end_of_run = last;
            expected_q.insert(expected_q.size(), beat);
         end
      endfunction

      // compare one result beat with the oldest expectation
      function void check_result(sample_type wm, logic eor);
         max_beat_type beat;
         if (expected_q.size() == 0) begin
            $error("unexpected result beat: window_max %0d end_of_run %0b", wm, eor);
            errors++;
         end else begin
            beat = expected_q[0];
            expected_q.delete(0);
            if (wm !== beat.window_max) begin
               $error("window_max mismatch: expected %0d, actual %0d", beat.window_max, wm);
               errors++;
            end
            if (eor !== beat.end_of_run) begin
               $error("end_of_run mismatch: expected %0b, actual %0b", beat.end_of_run, eor);
               errors++;
            end
         end
      endfunction
   endclass
endpackage

module testbench;
   import swm_pkg::*;
   import swm_tb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET     = 1800;
   localparam int PHASE_ITEMS     = 100;
   localparam int DRAIN_CYCLES    = 200;
   localparam int HOLD_OFF_CYCLES = 1500;
   localparam int STALL_LIMIT     = 20000;
   localparam int HOLD_PHASE      = 4;

   logic clock;
   logic reset;

   swm_req_if req_if ();
   swm_rsp_if rsp_if ();
   swm_csr_if csr_if ();

   sliding_window_maximum i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   window_max_scoreboard sb;
   int   send_idle_pct;
   int   recv_stall_pct;
   logic hold_off_req;
   int   items_sent;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result ready: random stalls, plus one long hold-off on request
   initial begin
      logic hold_done;
      hold_done    = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // result monitor
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.window_max, rsp_if.end_of_run);
      end
   end

   // watchdog: cycles in a row with no beat on any channel
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("[sliding_window_maximum] ERROR");
      $finish;
   end

   // one sample beat, after a random gap; returns at a falling edge
   task automatic send_sample(input sample_type s, input logic first, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.sample <= s;
      req_if.first  <= first;
      req_if.last   <= last;
      do @(posedge clock); while (!req_if.ready);
      sb.note_sample(s, first, last);
      items_sent++;
      @(negedge clock);
   endtask

   // window length write; only called while the block is idle
   task automatic write_window_len(input cfg_type v);
      csr_if.valid      <= 1'b1;
      csr_if.window_len <= v;
      do @(posedge clock); while (!csr_if.ready);
      sb.set_window_len(v);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // stop sending, wait out all results and any beat that makes none
   task automatic drain_pipeline();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // one sequence of n beats with a random value shape
   task automatic send_sequence(input int n, input logic start);
      int         shape;
      int         level;
      sample_type s;
      logic       f;
      logic       l;
      shape = $urandom_range(3);
      level = int'($urandom_range(65535)) - 32768;
      for (int k = 0; k < n; k++) begin
         case (shape)
            0: s = sample_type'($urandom);
            // narrow range, lots of ties
            1: s = sample_type'(int'($urandom_range(6)) - 3);
            // falling run keeps many candidates queued
            2: begin
               level = level - int'($urandom_range(3));
               s     = sample_type'(level);
            end
            default: begin
               level = level + int'($urandom_range(3));
               s     = sample_type'(level);
            end
         endcase
         // mostly clean framing, with a little stray first/last noise
         f = (k == 0) ? start : ($urandom_range(99) < 2);
         l = (k == n - 1) ? 1'b1 : ($urandom_range(99) < 4);
         send_sample(s, f, l);
      end
   endtask

   // main stimulus
   initial begin
      cfg_type   corner_len [6];
      cfg_type   v;
      int        phase;
      int        mode;
      int        eff_len;
      int        n;
      int        phase_end;
      int        r;
      logic      start;
      logic      opening;

      corner_len     = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd2};
      sb             = new();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_req   = 1'b0;
      items_sent     = 0;

      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.sample     = '0;
      req_if.first      = 1'b0;
      req_if.last       = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.window_len = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, ties, early last, first with last
      write_window_len(7'd3);
      send_sample(16'sh7fff, 1'b1, 1'b0);
      send_sample(16'sh8000, 1'b0, 1'b1);
      send_sample(16'sh8000, 1'b0, 1'b0);
      send_sample(16'sh8000, 1'b0, 1'b0);
      send_sample(16'sh0000, 1'b0, 1'b0);
      send_sample(16'shffff, 1'b0, 1'b0);
      send_sample(16'sd5, 1'b0, 1'b0);
      send_sample(16'sd5, 1'b0, 1'b0);
      send_sample(16'sd5, 1'b0, 1'b1);
      send_sample(16'shffff, 1'b1, 1'b1);
      send_sample(16'shfffe, 1'b0, 1'b0);
      send_sample(16'shfffd, 1'b0, 1'b1);
      drain_pipeline();
      write_window_len(7'd1);
      send_sample(16'sh8000, 1'b1, 1'b1);
      send_sample(16'sh7fff, 1'b0, 1'b0);
      send_sample(16'sh0000, 1'b0, 1'b1);

      // random phases
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         drain_pipeline();
         mode = phase % 4;
         case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         if (phase < 6) v = corner_len[phase];
         else begin
            r = $urandom_range(9);
            if (r < 5) v = cfg_type'($urandom_range(1, 8));
            else if (r < 8) v = cfg_type'($urandom_range(9, 64));
            else v = cfg_type'($urandom_range(127));
         end
         write_window_len(v);
         eff_len = (v == 0) ? 1 : ((v > WINDOW_MAX) ? WINDOW_MAX : int'(v));
         // long receiver hold-off while samples keep coming
         if (phase == HOLD_PHASE) hold_off_req = 1'b1;
         phase_end = items_sent + PHASE_ITEMS;
         opening   = 1'b1;
         while (items_sent < phase_end) begin
            if ($urandom_range(99) < 80) n = eff_len + int'($urandom_range(eff_len + 8));
            else n = int'($urandom_range(1, eff_len));
            // sometimes carry the old sequence over into the new length
            start   = opening ? ($urandom_range(99) < 70) : 1'b1;
            opening = 1'b0;
            send_sequence(n, start);
         end
         phase++;
      end

      drain_pipeline();
      if (sb.errors == 0)
         $display("[sliding_window_maximum] OK");
      else
         $display("[sliding_window_maximum] ERROR");
      $finish;
   end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/swm_pkg.sv
hw/rtl/swm_req_if.sv
hw/rtl/swm_rsp_if.sv
hw/rtl/swm_csr_if.sv
hw/rtl/swm_ctrl.sv
hw/rtl/swm_datapath.sv
hw/rtl/sliding_window_maximum.sv
tb/sv/testbench.sv
